// ----- hdl/docp_pkg.sv -----
// ----------------------------------------------------------------------------
// docp_pkg
// Shared widths, register indexes, cell payload types and the CORDIC
// arctangent table of the disk obstacle collide and project core.
// ----------------------------------------------------------------------------
`default_nettype none

package docp_pkg;

    // Coordinate and register widths.
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int CFG_IDX_W = 2;

    // Default parameter values.
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_RADIUS = 2'd2;

    // Square root cell widths: a 66-bit radicand, one root bit per cell.
    localparam int SQ_RAD_W  = 66;
    localparam int SQ_REM_W  = 35;
    localparam int SQ_ROOT_W = 33;
    localparam int SQRT_CELLS = SQ_RAD_W / 2;

    // Divider cell widths: one quotient bit per cell.
    localparam int DV_REM_W = 33;
    localparam int DV_NUM_W = COORD_W - 1;
    localparam int DV_Q_W   = COORD_W - 1;

    // CORDIC datapath width: magnitudes normalized into [2^40, 2^41).
    localparam int CR_W = 44;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt_cell;

    typedef struct packed {
        logic [DV_REM_W-1:0]  rem;
        logic [DV_NUM_W-1:0]  num;
        logic [DV_Q_W-1:0]    q;
        logic [SQ_ROOT_W-1:0] dvsr;
    } t_div_cell;

    typedef struct packed {
        logic signed [CR_W-1:0] x;
        logic signed [CR_W-1:0] y;
        logic [31:0]            z;
    } t_cordic_cell;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/docp_in_if.sv -----
// ----------------------------------------------------------------------------
// docp_in_if
// Valid/ready channel that carries one particle position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface docp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [docp_pkg::COORD_W-1:0] pos_x;
    logic signed [docp_pkg::COORD_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/docp_out_if.sv -----
// ----------------------------------------------------------------------------
// docp_out_if
// Valid/ready channel that carries one collision and projection result per
// beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface docp_out_if #(
    parameter int ANGLE_BITS = docp_pkg::ANGLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                collided;
    logic [ANGLE_BITS-1:0]               angle_low;
    logic [ANGLE_BITS:0]                 angle_high;
    logic signed [docp_pkg::COORD_W-1:0] proj_x;
    logic signed [docp_pkg::COORD_W-1:0] proj_y;
    logic                                at_center;

    modport source (output valid, output collided, output angle_low, output angle_high,
                    output proj_x, output proj_y, output at_center, input ready);
    modport sink   (input valid, input collided, input angle_low, input angle_high,
                    input proj_x, input proj_y, input at_center, output ready);
endinterface

`default_nettype wire

// ----- hdl/docp_delay.sv -----
// ----------------------------------------------------------------------------
// docp_delay
// Shift line that carries side data alongside the arithmetic cells so that
// it reaches the output stage with its own beat.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_line [0:DEPTH-1];

    // Every tap moves one place when the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

`default_nettype wire

// ----- hdl/docp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// docp_sqrt_cell
// One digit of a restoring integer square root: takes the next bit pair of
// the radicand and decides one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_sqrt_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire docp_pkg::t_sqrt_cell i_cell,
    output docp_pkg::t_sqrt_cell      o_cell
);

    logic [docp_pkg::SQ_REM_W+1:0] rem_sh;
    logic [docp_pkg::SQ_REM_W+1:0] trial;
    logic                          take;
    docp_pkg::t_sqrt_cell          n_cell;
    docp_pkg::t_sqrt_cell          r_cell;

    // Bring in the next bit pair and try to subtract 4*root+1.
    always_comb begin
        rem_sh = {i_cell.rem, i_cell.rad[docp_pkg::SQ_RAD_W-1 -: 2]};
        trial  = {{(docp_pkg::SQ_REM_W - docp_pkg::SQ_ROOT_W){1'b0}}, i_cell.root, 2'b01};
        take   = (rem_sh >= trial);
        n_cell.rad  = {i_cell.rad[docp_pkg::SQ_RAD_W-3:0], 2'b00};
        n_cell.rem  = take ? docp_pkg::SQ_REM_W'(rem_sh - trial)
                           : rem_sh[docp_pkg::SQ_REM_W-1:0];
        n_cell.root = {i_cell.root[docp_pkg::SQ_ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ----- hdl/docp_div_cell.sv -----
// ----------------------------------------------------------------------------
// docp_div_cell
// One step of a restoring divider: shifts in the next numerator bit and
// decides one quotient bit against the distance.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire docp_pkg::t_div_cell i_cell,
    output docp_pkg::t_div_cell      o_cell
);

    logic [docp_pkg::DV_REM_W:0] rem_sh;
    logic [docp_pkg::DV_REM_W:0] dvs;
    logic                        take;
    docp_pkg::t_div_cell         n_cell;
    docp_pkg::t_div_cell         r_cell;

    // Compare and subtract; the remainder stays below the divisor whenever the divisor is nonzero.
    always_comb begin
        rem_sh = {i_cell.rem, i_cell.num[docp_pkg::DV_NUM_W-1]};
        dvs    = {1'b0, i_cell.dvsr};
        take   = (rem_sh >= dvs);
        n_cell.rem  = take ? docp_pkg::DV_REM_W'(rem_sh - dvs)
                           : rem_sh[docp_pkg::DV_REM_W-1:0];
        n_cell.num  = {i_cell.num[docp_pkg::DV_NUM_W-2:0], 1'b0};
        n_cell.q    = {i_cell.q[docp_pkg::DV_Q_W-2:0], take};
        n_cell.dvsr = i_cell.dvsr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ----- hdl/docp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// docp_cordic_cell
// One CORDIC vectoring iteration: rotates the vector toward the x axis and
// accumulates the rotation angle.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire docp_pkg::t_cordic_cell i_cell,
    output docp_pkg::t_cordic_cell      o_cell
);

    logic signed [docp_pkg::CR_W-1:0] xs;
    logic signed [docp_pkg::CR_W-1:0] ys;
    docp_pkg::t_cordic_cell           n_cell;
    docp_pkg::t_cordic_cell           r_cell;

    // Rotate clockwise while y is above the axis, else counterclockwise.
    always_comb begin
        xs = $signed(i_cell.x) >>> STEP;
        ys = $signed(i_cell.y) >>> STEP;
        if ($signed(i_cell.y) > 0) begin
            n_cell.x = i_cell.x + ys;
            n_cell.y = i_cell.y - xs;
            n_cell.z = i_cell.z + docp_pkg::atan_turn(STEP);
        end else begin
            n_cell.x = i_cell.x - ys;
            n_cell.y = i_cell.y + xs;
            n_cell.z = i_cell.z - docp_pkg::atan_turn(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ----- hdl/disk_obstacle_collide_project_core.sv -----
// ----------------------------------------------------------------------------
// disk_obstacle_collide_project_core
// Tests a particle against one disk, gives its escape angle interval and
// projects it onto the disk edge.
// ----------------------------------------------------------------------------
// The core takes one position beat per clock while the output does not stall
// and gives one result beat per position, in order. The pipeline is
// a row of cells: partial-product multipliers for the squares and the
// radius products, 33 square root cells (one root bit each), 31 divider
// cells per axis (one quotient bit each), and in parallel six normalizing
// shift stages and CORDIC_STEPS CORDIC cells, capped at ATAN_ENTRIES, whose angle rides a shift line
// to the end. The whole row advances together; it holds while the output
// beat waits, so i_in.ready follows o_out.ready when a result is pending.
// Write the center and radius registers only while no position is in flight.
// A particle exactly at the center reports at_center and collided and
// passes its position through unchanged.
`default_nettype none

module disk_obstacle_collide_project_core #(
    parameter int ANGLE_BITS   = docp_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = docp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [docp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [docp_pkg::COORD_W-1:0]     i_cfg_data,
    docp_in_if.sink                               i_in,
    docp_out_if.source                            o_out
);

    localparam int CW  = docp_pkg::COORD_W;
    localparam int RW  = docp_pkg::RADIUS_W;
    localparam int NW  = docp_pkg::CR_W;
    localparam int DW  = CW + 1;
    localparam int NC  = (CORDIC_STEPS < docp_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                 : docp_pkg::ATAN_ENTRIES;
    localparam int NORM_STAGES = 6;
    localparam int HW  = (DW + 1) / 2;
    localparam int LW  = DW - HW;
    localparam int ST_SQ_OUT  = 4 + docp_pkg::SQRT_CELLS;
    localparam int ST_DIV_OUT = ST_SQ_OUT + 1 + docp_pkg::DV_Q_W;
    localparam int ST_OUT     = ST_DIV_OUT + 1;
    localparam int ST_CR_OUT  = 2 + NORM_STAGES + NC;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 ctr;
        logic                 neg_x;
        logic                 neg_y;
    } t_side;

    // Configuration registers and the beat valid line.
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic [RW-1:0]        r_r;
    logic                 r_v [0:ST_OUT];
    logic                 en;

    assign en         = !r_v[ST_OUT] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_r  <= RW'(65536);
            for (int k = 0; k <= ST_OUT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    docp_pkg::CFG_CENTER_X:    r_cx <= i_cfg_data;
                    docp_pkg::CFG_CENTER_Y:    r_cy <= i_cfg_data;
                    docp_pkg::CFG_DISK_RADIUS: r_r  <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (en) begin
                r_v[0] <= i_in.valid;
                for (int k = 1; k <= ST_OUT; k++) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0 to 4: offsets, squares, radius products and the collision test.
    logic signed [CW-1:0] r_px0, r_py0;
    logic signed [DW-1:0] r_dx1, r_dy1;
    logic [DW-1:0]        r_ax1, r_ay1;
    t_side                r_side1;
    logic [2*HW-1:0]      r_p11x, r_p11y;
    logic [HW+LW-1:0]     r_p10x, r_p10y;
    logic [2*LW-1:0]      r_p00x, r_p00y;
    logic [2*RW-1:0]      r_rr;
    logic [HW+RW-1:0]     r_a1rx, r_a1ry;
    logic [LW+RW-1:0]     r_a0rx, r_a0ry;
    logic [2*CW-1:0]      r_sqx, r_sqy, r_mxr, r_myr;
    logic [2*CW:0]        r_sum;
    logic                 r_coll;
    logic signed [DW-1:0] dx, dy;
    logic [2*CW:0]        n_sum;

    always_comb begin
        dx    = DW'(r_px0) - DW'(r_cx);
        dy    = DW'(r_py0) - DW'(r_cy);
        n_sum = (2*CW+1)'(r_sqx) + (2*CW+1)'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px0 <= i_in.pos_x;
            r_py0 <= i_in.pos_y;

            r_dx1 <= dx;
            r_dy1 <= dy;
            r_ax1 <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            r_ay1 <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            r_side1 <= '{px: r_px0, py: r_py0, ctr: (dx == '0) && (dy == '0),
                         neg_x: dx[DW-1], neg_y: dy[DW-1]};

            r_p11x <= (2*HW)'(r_ax1[DW-1:LW]) * (2*HW)'(r_ax1[DW-1:LW]);
            r_p10x <= (HW+LW)'(r_ax1[DW-1:LW]) * (HW+LW)'(r_ax1[LW-1:0]);
            r_p00x <= (2*LW)'(r_ax1[LW-1:0]) * (2*LW)'(r_ax1[LW-1:0]);
            r_p11y <= (2*HW)'(r_ay1[DW-1:LW]) * (2*HW)'(r_ay1[DW-1:LW]);
            r_p10y <= (HW+LW)'(r_ay1[DW-1:LW]) * (HW+LW)'(r_ay1[LW-1:0]);
            r_p00y <= (2*LW)'(r_ay1[LW-1:0]) * (2*LW)'(r_ay1[LW-1:0]);
            r_rr   <= (2*RW)'(r_r) * (2*RW)'(r_r);
            r_a1rx <= (HW+RW)'(r_ax1[DW-1:LW]) * (HW+RW)'(r_r);
            r_a0rx <= (LW+RW)'(r_ax1[LW-1:0]) * (LW+RW)'(r_r);
            r_a1ry <= (HW+RW)'(r_ay1[DW-1:LW]) * (HW+RW)'(r_r);
            r_a0ry <= (LW+RW)'(r_ay1[LW-1:0]) * (LW+RW)'(r_r);

            r_sqx <= ((2*CW)'(r_p11x) << (2*LW)) + ((2*CW)'(r_p10x) << (LW+1))
                     + (2*CW)'(r_p00x);
            r_sqy <= ((2*CW)'(r_p11y) << (2*LW)) + ((2*CW)'(r_p10y) << (LW+1))
                     + (2*CW)'(r_p00y);
            r_mxr <= ((2*CW)'(r_a1rx) << LW) + (2*CW)'(r_a0rx);
            r_myr <= ((2*CW)'(r_a1ry) << LW) + (2*CW)'(r_a0ry);

            r_sum  <= n_sum;
            r_coll <= (n_sum <= (2*CW+1)'(r_rr));
        end
    end

    // CORDIC preparation: fold the left half-plane over by a half turn.
    logic signed [NW-1:0] xe, ye, x0, y0, ay0;
    logic signed [NW-1:0] r_nx [0:NORM_STAGES];
    logic signed [NW-1:0] r_ny [0:NORM_STAGES];
    logic [NW-1:0]        r_nm [0:NORM_STAGES];
    logic [31:0]          r_nz [0:NORM_STAGES];

    always_comb begin
        xe  = NW'(r_dx1);
        ye  = NW'(r_dy1);
        x0  = r_dx1[DW-1] ? -xe : xe;
        y0  = r_dx1[DW-1] ? -ye : ye;
        ay0 = y0[NW-1] ? -y0 : y0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx[0] <= x0;
            r_ny[0] <= y0;
            r_nm[0] <= (x0 > ay0) ? x0 : ay0;
            r_nz[0] <= r_dx1[DW-1] ? 32'h8000_0000 : 32'h0;
        end
    end

    // Normalizing shifts by 32, 16, ... 1, then one final doubling.
    for (genvar k = 1; k <= NORM_STAGES; k++) begin : g_norm
        localparam int SH = 32 >> (k - 1);
        logic sel;
        logic signed [NW-1:0] n_x, n_y;
        logic [NW-1:0]        n_m;

        always_comb begin
            sel = (r_nm[k-1] < (NW'(1) << (40 - SH)));
            n_x = sel ? (r_nx[k-1] <<< SH) : r_nx[k-1];
            n_y = sel ? (r_ny[k-1] <<< SH) : r_ny[k-1];
            n_m = sel ? (r_nm[k-1] << SH) : r_nm[k-1];
            if (k == NORM_STAGES) begin
                n_x = n_x <<< 1;
                n_y = n_y <<< 1;
                n_m = n_m << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nx[k] <= n_x;
                r_ny[k] <= n_y;
                r_nm[k] <= n_m;
                r_nz[k] <= r_nz[k-1];
            end
        end
    end

    // CORDIC cell row.
    docp_pkg::t_cordic_cell w_cr [0:NC];

    assign w_cr[0] = '{x: r_nx[NORM_STAGES], y: r_ny[NORM_STAGES], z: r_nz[NORM_STAGES]};

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        docp_cordic_cell #(.STEP(i)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cell (w_cr[i]),
            .o_cell (w_cr[i+1])
        );
    end

    // Square root cell row.
    docp_pkg::t_sqrt_cell w_sq [0:docp_pkg::SQRT_CELLS];

    assign w_sq[0] = '{rad: docp_pkg::SQ_RAD_W'(r_sum), rem: '0, root: '0};

    for (genvar j = 0; j < docp_pkg::SQRT_CELLS; j++) begin : g_sqrt
        docp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cell (w_sq[j]),
            .o_cell (w_sq[j+1])
        );
    end

    // Side data shift lines.
    logic [4*CW-1:0]      mr_d;
    t_side                side_d;
    logic                 coll_d;
    logic [31:0]          z_d;

    docp_delay #(.W(4*CW), .DEPTH(ST_SQ_OUT - 3)) u_mr_dly (
        .i_clk (i_clk), .i_en (en), .i_data ({r_mxr, r_myr}), .o_data (mr_d)
    );

    docp_delay #(.W($bits(t_side)), .DEPTH(ST_DIV_OUT - 1)) u_side_dly (
        .i_clk (i_clk), .i_en (en), .i_data (r_side1), .o_data (side_d)
    );

    docp_delay #(.W(1), .DEPTH(ST_DIV_OUT - 4)) u_coll_dly (
        .i_clk (i_clk), .i_en (en), .i_data (r_coll), .o_data (coll_d)
    );

    docp_delay #(.W(32), .DEPTH(ST_DIV_OUT - ST_CR_OUT)) u_z_dly (
        .i_clk (i_clk), .i_en (en), .i_data (w_cr[NC].z), .o_data (z_d)
    );

    // Numerators with half the distance added for rounding.
    logic [2*CW-1:0]     num_x, num_y;
    docp_pkg::t_div_cell r_dvx0, r_dvy0;

    always_comb begin
        num_x = mr_d[4*CW-1:2*CW] + (2*CW)'(w_sq[docp_pkg::SQRT_CELLS].root >> 1);
        num_y = mr_d[2*CW-1:0]    + (2*CW)'(w_sq[docp_pkg::SQRT_CELLS].root >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvx0 <= '{rem: num_x[2*CW-1:docp_pkg::DV_NUM_W],
                        num: num_x[docp_pkg::DV_NUM_W-1:0], q: '0,
                        dvsr: w_sq[docp_pkg::SQRT_CELLS].root};
            r_dvy0 <= '{rem: num_y[2*CW-1:docp_pkg::DV_NUM_W],
                        num: num_y[docp_pkg::DV_NUM_W-1:0], q: '0,
                        dvsr: w_sq[docp_pkg::SQRT_CELLS].root};
        end
    end

    // Divider cell rows, one per axis.
    docp_pkg::t_div_cell w_dx [0:docp_pkg::DV_Q_W];
    docp_pkg::t_div_cell w_dy [0:docp_pkg::DV_Q_W];

    assign w_dx[0] = r_dvx0;
    assign w_dy[0] = r_dvy0;

    for (genvar j = 0; j < docp_pkg::DV_Q_W; j++) begin : g_div
        docp_div_cell u_cell_x (
            .i_clk (i_clk), .i_en (en), .i_cell (w_dx[j]), .o_cell (w_dx[j+1])
        );
        docp_div_cell u_cell_y (
            .i_clk (i_clk), .i_en (en), .i_cell (w_dy[j]), .o_cell (w_dy[j+1])
        );
    end

    // Output stage: signed projection with saturation and angle rounding.
    localparam logic signed [CW+1:0] LIM_HI = (CW+2)'((64'(1) << (CW - 1)) - 1);
    localparam logic signed [CW+1:0] LIM_LO = -LIM_HI - 1;

    logic signed [CW+1:0]  vx, vy, qx, qy;
    logic signed [CW-1:0]  n_proj_x, n_proj_y;
    logic [31:0]           z_rnd;
    logic [ANGLE_BITS-1:0] phi, n_low;
    logic [ANGLE_BITS:0]   n_high;

    always_comb begin
        qx = (CW+2)'(w_dx[docp_pkg::DV_Q_W].q);
        qy = (CW+2)'(w_dy[docp_pkg::DV_Q_W].q);
        vx = side_d.neg_x ? (CW+2)'(r_cx) - qx : (CW+2)'(r_cx) + qx;
        vy = side_d.neg_y ? (CW+2)'(r_cy) - qy : (CW+2)'(r_cy) + qy;
        if (side_d.ctr) begin
            n_proj_x = side_d.px;
        end else if (vx > LIM_HI) begin
            n_proj_x = LIM_HI[CW-1:0];
        end else if (vx < LIM_LO) begin
            n_proj_x = LIM_LO[CW-1:0];
        end else begin
            n_proj_x = vx[CW-1:0];
        end
        if (side_d.ctr) begin
            n_proj_y = side_d.py;
        end else if (vy > LIM_HI) begin
            n_proj_y = LIM_HI[CW-1:0];
        end else if (vy < LIM_LO) begin
            n_proj_y = LIM_LO[CW-1:0];
        end else begin
            n_proj_y = vy[CW-1:0];
        end
        z_rnd  = z_d + (32'(1) << (31 - ANGLE_BITS));
        phi    = side_d.ctr ? '0 : z_rnd[31 -: ANGLE_BITS];
        n_low  = phi - ANGLE_BITS'(1 << (ANGLE_BITS - 2));
        n_high = (ANGLE_BITS+1)'(n_low) + (ANGLE_BITS+1)'(1 << (ANGLE_BITS - 1));
    end

    logic                  r_o_coll, r_o_ctr;
    logic [ANGLE_BITS-1:0] r_o_low;
    logic [ANGLE_BITS:0]   r_o_high;
    logic signed [CW-1:0]  r_o_px, r_o_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_coll <= coll_d;
            r_o_ctr  <= side_d.ctr;
            r_o_low  <= n_low;
            r_o_high <= n_high;
            r_o_px   <= n_proj_x;
            r_o_py   <= n_proj_y;
        end
    end

    assign o_out.valid      = r_v[ST_OUT];
    assign o_out.collided   = r_o_coll;
    assign o_out.angle_low  = r_o_low;
    assign o_out.angle_high = r_o_high;
    assign o_out.proj_x     = r_o_px;
    assign o_out.proj_y     = r_o_py;
    assign o_out.at_center  = r_o_ctr;

endmodule

`default_nettype wire

// ----- hdl/docp_checker.sv -----
// ----------------------------------------------------------------------------
// docp_checker
// Port-level checks of the disk obstacle core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_port_checks #(
    parameter int ANGLE_BITS = docp_pkg::ANGLE_BITS_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic                           i_collided,
    input wire logic [ANGLE_BITS-1:0]          i_angle_low,
    input wire logic [ANGLE_BITS:0]            i_angle_high,
    input wire logic [docp_pkg::COORD_W-1:0]   i_proj_x,
    input wire logic [docp_pkg::COORD_W-1:0]   i_proj_y,
    input wire logic                           i_at_center
);

    // A particle at the center always lies inside the disk.
    a_center_collides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_at_center) |-> i_collided)
        else $error("at_center without collided");

    // The upper angle is the lower angle plus a half turn.
    a_half_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle_high ==
            (ANGLE_BITS+1)'(i_angle_low) + (ANGLE_BITS+1)'(1 << (ANGLE_BITS - 1))))
        else $error("angle_high is not angle_low plus a half turn");

    // At the center the lower angle is three quarter turns.
    a_center_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_at_center) |->
            (i_angle_low == ANGLE_BITS'(3 << (ANGLE_BITS - 2))))
        else $error("center angle is not three quarter turns");

    // A pending result holds the input side.
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while the pipeline is stalled");

    // A stalled result beat holds its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable({i_collided, i_angle_low, i_angle_high, i_proj_x, i_proj_y,
                     i_at_center})))
        else $error("stalled result beat changed");

endmodule

bind disk_obstacle_collide_project_core docp_port_checks #(.ANGLE_BITS(ANGLE_BITS))
    u_docp_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_collided   (o_out.collided),
    .i_angle_low  (o_out.angle_low),
    .i_angle_high (o_out.angle_high),
    .i_proj_x     (o_out.proj_x),
    .i_proj_y     (o_out.proj_y),
    .i_at_center  (o_out.at_center)
);

`default_nettype wire

// ----- verif/docp_checker.sv -----
// ----------------------------------------------------------------------------
// docp_checker
// Watches the position and result channels and the register write port of
// the disk obstacle core. It predicts each result in order and compares the
// results field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module docp_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [docp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [docp_pkg::COORD_W-1:0]   i_cfg_data,
    docp_in_if                                  in_ch,
    docp_out_if                                 out_ch,
    output int                                  o_errors,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        collided;
        logic [15:0] angle_low;
        logic [16:0] angle_high;
        logic [31:0] proj_x;
        logic [31:0] proj_y;
        logic        at_center;
    } disk_result_t;

    // Copy of the disk registers.
    logic signed [31:0] disk_cx;
    logic signed [31:0] disk_cy;
    logic [30:0]        disk_r;

    disk_result_t expected_results[$];

    // Arctangent table, 2^32 units per turn.
    logic [31:0] arc_tab [0:15] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861
    };

    // Edge projection of one axis, rounded half away from zero, saturated.
    function automatic longint edge_coord(longint c, longint d, logic [63:0] r,
                                          logic [63:0] dvsr);
        logic [63:0] mag;
        logic [63:0] q;
        longint      v;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q = (mag * r + dvsr / 2) / dvsr;
        v = (d < 0) ? c - longint'(q) : c + longint'(q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    // Direction of (x, y) by CORDIC vectoring, 2^32 units per turn.
    function automatic logic [31:0] heading(longint x, longint y);
        logic [31:0] z;
        longint      m;
        longint      xs;
        longint      ys;
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        m = (y < 0) ? -y : y;
        if (x > m) m = x;
        while (m < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arc_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arc_tab[i];
            end
        end
        return z;
    endfunction

    function automatic disk_result_t disk_response(logic signed [31:0] px,
                                                   logic signed [31:0] py);
        disk_result_t res;
        longint       dx;
        longint       dy;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [65:0]  dsq;
        logic [63:0]  root;
        logic [63:0]  rem;
        logic [63:0]  trial;
        logic [63:0]  z64;
        logic [15:0]  phi;
        logic [15:0]  low;
        dx = longint'(px) - longint'(disk_cx);
        dy = longint'(py) - longint'(disk_cy);
        ax = (dx < 0) ? 64'(-dx) : 64'(dx);
        ay = (dy < 0) ? 64'(-dy) : 64'(dy);
        dsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        res.collided = (dsq <= 66'(disk_r) * 66'(disk_r));
        res.at_center = (dx == 0 && dy == 0);
        res.proj_x = px;
        res.proj_y = py;
        phi = 16'd0;
        if (!res.at_center) begin
            z64 = 64'(heading(dx, dy)) + 64'd32768;
            phi = z64[31:16];
            // Integer square root, two radicand bits per step.
            root = 64'd0;
            rem = 64'd0;
            for (int i = 32; i >= 0; i--) begin
                rem = (rem << 2) | 64'(dsq[2*i +: 2]);
                trial = (root << 2) | 64'd1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            res.proj_x = 32'(edge_coord(longint'(disk_cx), dx, 64'(disk_r), root));
            res.proj_y = 32'(edge_coord(longint'(disk_cy), dy, 64'(disk_r), root));
        end
        low = phi + 16'hC000;
        res.angle_low = low;
        res.angle_high = 17'(low) + 17'd32768;
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // Track registers, predict on each position beat, check each result beat.
    always @(posedge i_clk) begin
        disk_result_t want;
        if (!i_rst_n) begin
            disk_cx <= '0;
            disk_cy <= '0;
            disk_r <= 31'd65536;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    docp_pkg::CFG_CENTER_X: disk_cx <= i_cfg_data;
                    docp_pkg::CFG_CENTER_Y: disk_cy <= i_cfg_data;
                    docp_pkg::CFG_DISK_RADIUS: disk_r <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(disk_response(in_ch.pos_x, in_ch.pos_y));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no position outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.collided !== want.collided ||
                        out_ch.angle_low !== want.angle_low ||
                        out_ch.angle_high !== want.angle_high ||
                        out_ch.proj_x !== want.proj_x ||
                        out_ch.proj_y !== want.proj_y ||
                        out_ch.at_center !== want.at_center)
                        o_errors <= o_errors + 1;
                    if (out_ch.collided !== want.collided)
                        $error("collided: expected %0d, got %0d",
                               want.collided, out_ch.collided);
                    if (out_ch.angle_low !== want.angle_low)
                        $error("angle_low: expected %0d, got %0d",
                               want.angle_low, out_ch.angle_low);
                    if (out_ch.angle_high !== want.angle_high)
                        $error("angle_high: expected %0d, got %0d",
                               want.angle_high, out_ch.angle_high);
                    if (out_ch.proj_x !== want.proj_x)
                        $error("proj_x: expected %0d, got %0d",
                               $signed(want.proj_x), out_ch.proj_x);
                    if (out_ch.proj_y !== want.proj_y)
                        $error("proj_y: expected %0d, got %0d",
                               $signed(want.proj_y), out_ch.proj_y);
                    if (out_ch.at_center !== want.at_center)
                        $error("at_center: expected %0d, got %0d",
                               want.at_center, out_ch.at_center);
                end
            end
        end
    end
endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the disk obstacle core with directed and random particle positions
// over several disk settings, with random gaps on both channels, and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 100;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [docp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [docp_pkg::COORD_W-1:0]   i_cfg_data;
    int                             errors;
    int                             pending;
    int                             cycles;
    bit                             no_idle;

    logic signed [31:0] cur_cx;
    logic signed [31:0] cur_cy;
    logic [30:0]        cur_r;

    docp_in_if  pos_ch ();
    docp_out_if res_ch ();

    disk_obstacle_collide_project_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(pos_ch.sink), .o_out(res_ch.source)
    );

    docp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(pos_ch), .out_ch(res_ch), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = gap_len();
            res_ch.ready = (stall == 0);
            repeat (stall) @(negedge i_clk);
        end
    end

    // Run timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_pos(logic [31:0] px, logic [31:0] py);
        int gap;
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            pos_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pos_ch.valid = 1'b1;
        pos_ch.pos_x = px;
        pos_ch.pos_y = py;
        do @(posedge i_clk); while (!pos_ch.ready);
    endtask

    task automatic write_reg(logic [docp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Let the pipe empty, then load a new disk.
    task automatic set_disk(logic [31:0] cx, logic [31:0] cy, logic [30:0] r);
        @(negedge i_clk);
        pos_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(docp_pkg::CFG_CENTER_X, cx);
        write_reg(docp_pkg::CFG_CENTER_Y, cy);
        write_reg(docp_pkg::CFG_DISK_RADIUS, {1'b0, r});
        cur_cx = cx;
        cur_cy = cy;
        cur_r = r;
    endtask

    // A random position: anywhere, near the center, inside the disk's bounding square, or at a random-scale offset.
    task automatic send_random();
        int          kind;
        logic [31:0] ox;
        logic [31:0] oy;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            send_pos($urandom, $urandom);
        end else if (kind < 5) begin
            ox = $urandom_range(0, 8) - 4;
            oy = $urandom_range(0, 8) - 4;
            send_pos(cur_cx + ox, cur_cy + oy);
        end else if (kind < 8) begin
            ox = $urandom_range(0, cur_r) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            oy = $urandom_range(0, cur_r) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            send_pos(cur_cx + ox, cur_cy + oy);
        end else begin
            ox = $signed($urandom) >>> $urandom_range(0, 31);
            oy = $signed($urandom) >>> $urandom_range(0, 31);
            send_pos(cur_cx + ox, cur_cy + oy);
        end
    endtask

    initial begin
        logic [31:0] rx;
        logic [31:0] ry;
        cycles = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        cur_cx = 0;
        cur_cy = 0;
        cur_r = 31'd65536;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset disk: center, edge, axes, extremes.
        send_pos(32'd0, 32'd0);
        send_pos(32'd65536, 32'd0);
        send_pos(32'd0, 32'd65536);
        send_pos(-32'sd65536, 32'd0);
        send_pos(32'd0, -32'sd65536);
        send_pos(32'd65537, 32'd0);
        send_pos(32'd46341, 32'd46341);
        send_pos(32'h7fff_ffff, 32'h7fff_ffff);
        send_pos(32'h8000_0000, 32'h8000_0000);
        send_pos(32'h8000_0000, 32'h7fff_ffff);
        send_pos(32'h7fff_ffff, 32'h8000_0000);
        send_pos(32'd1, 32'd0);
        send_pos(32'hffff_ffff, 32'hffff_ffff);
        send_pos(-32'sd65536, 32'd1);
        send_pos(-32'sd65536, -32'sd1);

        // Far corners: largest offsets and saturating projections.
        set_disk(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        send_pos(32'h8000_0000, 32'h7fff_ffff);
        send_pos(32'h7fff_ffff, 32'h8000_0000);
        send_pos(32'h7fff_ffff, 32'h7fff_ffff);
        send_pos(32'h0, 32'h0);
        set_disk(32'h8000_0000, 32'h7fff_ffff, 31'd0);
        send_pos(32'h7fff_ffff, 32'h8000_0000);
        send_pos(32'h8000_0000, 32'h7fff_ffff);
        send_pos(32'h8000_0001, 32'h7fff_ffff);

        // Random phases over several disks, the extremes among them.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: set_disk(32'd0, 32'd0, 31'd65536);
                1: set_disk(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
                2: set_disk(32'h8000_0000, 32'h8000_0000, 31'd0);
                3: set_disk(32'd0, 32'd0, 31'd1);
                default: begin
                    rx = $urandom;
                    ry = $urandom;
                    set_disk(rx, ry, 31'($urandom) >> $urandom_range(0, 30));
                end
            endcase
            no_idle = (phase % 3 == 1);
            repeat (200) send_random();
        end

        @(negedge i_clk);
        pos_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
